// File: hw/rtl/pbsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbsm_pkg;
    localparam int VIRT_BLOCKS = 64;
    localparam int PHYS_FRAMES = 16;
    localparam int PAGE_BYTES  = 4096;
    localparam int BLK_W   = $clog2(VIRT_BLOCKS);
    localparam int FRM_W   = $clog2(PHYS_FRAMES);
    localparam int SIZE_W  = 13;
    localparam int OFS_W   = 32;

    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_ACCESS = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOALLOC = 2'd2;

    typedef struct packed {
        logic [1:0]        mode;
        logic [5:0]        block_index;
        logic [SIZE_W-1:0] alloc_size;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        result_block;
        logic [4:0]        frame;
        logic              evict_valid;
        logic [5:0]        evict_block;
        logic [OFS_W-1:0]  evict_offset;
        logic [SIZE_W-1:0] evict_size;
        logic              fetch_valid;
        logic [OFS_W-1:0]  fetch_offset;
        logic [SIZE_W-1:0] fetch_size;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/pbsm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pbsm_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pbsm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pbsm_ctrl
    import pbsm_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  in_valid,
    output logic in_ready,
    output logic out_valid,
    input  wire  out_ready,
    output cmd_t cmd,
    input  sts_t sts
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign cmd.load  = in_valid && in_ready;
    assign cmd.exec  = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: if (sts.done) state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_exec_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec) else $error("load not followed by exec");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/pbsm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pbsm_dp
    import pbsm_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp
);
    logic [VIRT_BLOCKS-1:0] used_reg, swapped_reg;
    logic [PHYS_FRAMES-1:0] fused_reg;
    logic [FRM_W-1:0]  bframe_reg [VIRT_BLOCKS];
    logic [SIZE_W-1:0] bsize_reg  [VIRT_BLOCKS];
    logic [OFS_W-1:0]  bofs_reg   [VIRT_BLOCKS];
    logic [OFS_W-1:0]  swap_end_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    logic [1:0] step_reg;

    // priority searches, registered with the load
    logic [BLK_W-1:0] free_blk, evict_blk;
    logic             free_blk_ok, evict_ok;
    logic [FRM_W-1:0] free_frm;
    logic             free_frm_ok;
    logic [BLK_W-1:0] fb_reg, eb_reg;
    logic             fb_ok_reg, eb_ok_reg;
    logic [FRM_W-1:0] ff_reg;
    logic             ff_ok_reg;
    logic [VIRT_BLOCKS-1:0] resident;

    // table entries of the addressed block and of the eviction candidate
    logic [FRM_W-1:0]  rd_frame_reg;
    logic [SIZE_W-1:0] rd_size_reg;
    logic [OFS_W-1:0]  rd_ofs_reg;
    logic [FRM_W-1:0]  ev_frame_reg;
    logic [SIZE_W-1:0] ev_size_reg;

    assign resident = used_reg & ~swapped_reg;

    always_comb
    begin
        free_blk = '0; free_blk_ok = 1'b0;
        evict_blk = '0; evict_ok = 1'b0;
        free_frm = '0; free_frm_ok = 1'b0;
        for (int i = VIRT_BLOCKS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_blk = BLK_W'(i); free_blk_ok = 1'b1;
            end
            if (resident[i])
            begin
                evict_blk = BLK_W'(i); evict_ok = 1'b1;
            end
        end
        for (int j = PHYS_FRAMES - 1; j >= 0; j--)
            if (!fused_reg[j])
            begin
                free_frm = FRM_W'(j); free_frm_ok = 1'b1;
            end
    end

    logic [BLK_W-1:0] idx;
    logic             known;
    logic [SIZE_W-1:0] sat_size;
    assign idx   = req_reg.block_index[BLK_W-1:0];
    assign known = used_reg[idx];
    assign sat_size = (req_reg.alloc_size > SIZE_W'(PAGE_BYTES)) ?
                      SIZE_W'(PAGE_BYTES) : req_reg.alloc_size;

    assign sts.done = cmd.exec && (step_reg == 2'd1);
    assign rsp = rsp_reg;

    // frame taken for alloc or swap-in, from registered search
    logic [FRM_W-1:0] take_f;
    logic             take_ev;
    always_comb
    begin
        take_ev = 1'b0;
        take_f  = '0;
        if (ff_ok_reg)
            take_f = ff_reg;
        else if (eb_ok_reg)
        begin
            take_ev = 1'b1;
            take_f  = ev_frame_reg;
        end
    end

    logic [VIRT_BLOCKS-1:0] used_next, swapped_next;
    logic [PHYS_FRAMES-1:0] fused_next;
    logic [OFS_W-1:0]       swap_end_next;
    rsp_t                   rsp_next;
    logic                   take_now;
    logic                   ev_now;
    logic                   frm_we;
    logic [BLK_W-1:0]       frm_wa;
    logic                   size_we;

    always_comb
    begin
        used_next     = used_reg;
        swapped_next  = swapped_reg;
        fused_next    = fused_reg;
        swap_end_next = swap_end_reg;
        take_now      = 1'b0;
        ev_now        = 1'b0;
        frm_we        = 1'b0;
        frm_wa        = fb_reg;
        size_we       = 1'b0;
        rsp_next              = '0;
        rsp_next.status       = ST_OK;
        rsp_next.result_block = req_reg.block_index;
        rsp_next.frame        = 5'h1f;
        case (req_reg.mode)
            MODE_ALLOC:
            begin
                rsp_next.result_block = '0;
                if (!fb_ok_reg)
                    rsp_next.status = ST_FULL;
                else
                begin
                    used_next[fb_reg] = 1'b1;
                    rsp_next.result_block = 6'(fb_reg);
                    rsp_next.frame = 5'(take_f);
                    take_now = 1'b1;
                    frm_we   = 1'b1;
                    frm_wa   = fb_reg;
                    size_we  = 1'b1;
                end
            end
            MODE_FREE:
                if (!known)
                    rsp_next.status = ST_NOALLOC;
                else
                begin
                    if (swapped_reg[idx])
                        swapped_next[idx] = 1'b0;
                    else
                        fused_next[rd_frame_reg] = 1'b0;
                    used_next[idx] = 1'b0;
                end
            MODE_ACCESS:
                if (!known)
                    rsp_next.status = ST_NOALLOC;
                else if (swapped_reg[idx])
                begin
                    swapped_next[idx] = 1'b0;
                    take_now = 1'b1;
                    frm_we   = 1'b1;
                    frm_wa   = idx;
                    rsp_next.frame = 5'(take_f);
                    rsp_next.fetch_valid  = 1'b1;
                    rsp_next.fetch_offset = rd_ofs_reg;
                    rsp_next.fetch_size   = rd_size_reg;
                end
                else
                    rsp_next.frame = 5'(rd_frame_reg);
            default:
                if (known && !swapped_reg[idx])
                    rsp_next.frame = 5'(rd_frame_reg);
        endcase
        if (take_now)
        begin
            if (ff_ok_reg)
                fused_next[ff_reg] = 1'b1;
            else if (take_ev)
            begin
                ev_now = 1'b1;
                swapped_next[eb_reg] = 1'b1;
                swap_end_next = swap_end_reg + OFS_W'(ev_size_reg);
                rsp_next.evict_valid  = 1'b1;
                rsp_next.evict_block  = 6'(eb_reg);
                rsp_next.evict_offset = swap_end_reg;
                rsp_next.evict_size   = ev_size_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            swapped_reg <= '0;
            fused_reg <= '0;
            swap_end_reg <= '0;
            step_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
        end
        else if (cmd.exec && step_reg == 2'd0)
        begin
            step_reg <= 2'd1;
        end
        else if (sts.done)
        begin
            step_reg <= 2'd2;
            used_reg <= used_next;
            swapped_reg <= swapped_next;
            fused_reg <= fused_next;
            swap_end_reg <= swap_end_next;
        end
    end

    // table payload and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
            fb_reg <= free_blk; fb_ok_reg <= free_blk_ok;
            eb_reg <= evict_blk; eb_ok_reg <= evict_ok;
            ff_reg <= free_frm; ff_ok_reg <= free_frm_ok;
            rd_frame_reg <= bframe_reg[req.block_index];
            rd_size_reg  <= bsize_reg[req.block_index];
            rd_ofs_reg   <= bofs_reg[req.block_index];
        end
        if (cmd.exec && step_reg == 2'd0)
        begin
            ev_frame_reg <= bframe_reg[eb_reg];
            ev_size_reg  <= bsize_reg[eb_reg];
        end
        if (sts.done)
        begin
            rsp_reg <= rsp_next;
            if (frm_we)
                bframe_reg[frm_wa] <= take_f;
            if (size_we)
                bsize_reg[fb_reg] <= sat_size;
            if (ev_now)
                bofs_reg[eb_reg] <= swap_end_reg;
        end
    end

`ifndef SYNTHESIS
    a_swapped_used: assert property (@(posedge clk) disable iff (!rst_n)
        ((swapped_reg & ~used_reg) == '0)) else $error("swapped block not in use");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |=> !sts.done) else $error("double completion");
    a_res_frames: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(resident) <= $countones(fused_reg)))
        else $error("more resident blocks than frames");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/paged_block_swap_manager.sv
`timescale 1ns / 1ps
`default_nettype none
// paged block swap manager: 64 virtual blocks on 16 frames; one item in, one
// result out. from accept to result valid each item passes the steps: load with
// priority search over the block and frame tables and read of the addressed
// entry, read of the eviction candidate, table update; a new item is taken only
// after the previous result has been taken.
module paged_block_swap_manager
    import pbsm_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    pbsm_if.sink   in_ch,
    pbsm_if.source out_ch
);
    cmd_t cmd;
    sts_t sts;
    rsp_t rsp;

    pbsm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .sts(sts)
    );

    pbsm_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .req(req_t'(in_ch.data)), .cmd(cmd), .sts(sts), .rsp(rsp)
    );

    assign out_ch.data = rsp;
endmodule
`default_nettype wire
